>>> rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg: texture surface size shared definitions
// Format descriptor table, block-width reciprocals and the side-band record
// that travels down the size pipeline.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int FMT_COUNT   = 77;
    localparam int FMT_NV12    = 75;
    localparam int FMT_YUV420  = 76;

    // Scaled reciprocal: ceil(x / d) = ((x + d - 1) * recip(d)) >> RECIP_SHIFT,
    // exact for any x below 2^17 and d up to 12.
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    typedef struct packed {
        logic [4:0] bytes;
        logic [3:0] bw;
        logic [3:0] bh;
        logic       ds;
        logic [1:0] planes;
    } t_fmt_desc;

    typedef struct packed {
        logic       err;
        logic       ds;
        logic [1:0] planes;
        logic [1:0] shift;
    } t_side;

    function automatic t_fmt_desc fmt_lookup(input logic [6:0] idx);
        t_fmt_desc d;
        d = '{bytes: 5'd0, bw: 4'd1, bh: 4'd1, ds: 1'b0, planes: 2'd1};
        case (idx) inside
            7'd0, 7'd1:                    d.bytes = 5'd1;
            7'd2, 7'd4, 7'd5, 7'd7:        d.bytes = 5'd2;
            7'd3, 7'd6, 7'd8, 7'd10,
            7'd11, 7'd13, [7'd17:7'd21]:   d.bytes = 5'd4;
            7'd9, 7'd12, 7'd15:            d.bytes = 5'd8;
            7'd14, 7'd16:                  d.bytes = 5'd16;
            [7'd22:7'd25], [7'd28:7'd31], 7'd39: begin
                d.bytes = 5'd8;
                d.bw    = 4'd4;
                d.bh    = 4'd4;
            end
            7'd26, 7'd27, [7'd32:7'd38], 7'd40, 7'd41, 7'd42, 7'd43: begin
                d.bytes = 5'd16;
                d.bw    = 4'd4;
                d.bh    = 4'd4;
            end
            7'd44, 7'd45: begin d.bytes = 5'd16; d.bw = 4'd5;  d.bh = 4'd4;  end
            7'd46, 7'd47: begin d.bytes = 5'd16; d.bw = 4'd5;  d.bh = 4'd5;  end
            7'd48, 7'd49: begin d.bytes = 5'd16; d.bw = 4'd6;  d.bh = 4'd5;  end
            7'd50, 7'd51: begin d.bytes = 5'd16; d.bw = 4'd6;  d.bh = 4'd6;  end
            7'd52, 7'd53: begin d.bytes = 5'd16; d.bw = 4'd8;  d.bh = 4'd5;  end
            7'd54, 7'd55: begin d.bytes = 5'd16; d.bw = 4'd8;  d.bh = 4'd6;  end
            7'd56, 7'd57: begin d.bytes = 5'd16; d.bw = 4'd8;  d.bh = 4'd8;  end
            7'd58, 7'd59: begin d.bytes = 5'd16; d.bw = 4'd10; d.bh = 4'd5;  end
            7'd60, 7'd61: begin d.bytes = 5'd16; d.bw = 4'd10; d.bh = 4'd6;  end
            7'd62, 7'd63: begin d.bytes = 5'd16; d.bw = 4'd10; d.bh = 4'd8;  end
            7'd64, 7'd65: begin d.bytes = 5'd16; d.bw = 4'd10; d.bh = 4'd10; end
            7'd66, 7'd67: begin d.bytes = 5'd16; d.bw = 4'd12; d.bh = 4'd10; end
            7'd68, 7'd69: begin d.bytes = 5'd16; d.bw = 4'd12; d.bh = 4'd12; end
            7'd70: begin d.bytes = 5'd2; d.ds = 1'b1; end
            7'd71: begin d.bytes = 5'd3; d.ds = 1'b1; end
            7'd72, 7'd73: begin d.bytes = 5'd4; d.ds = 1'b1; end
            7'd74: begin d.bytes = 5'd5; d.ds = 1'b1; end
            7'd75: begin
                d.bytes  = 5'd24;
                d.bw     = 4'd4;
                d.bh     = 4'd4;
                d.planes = 2'd2;
            end
            7'd76: begin
                d.bytes  = 5'd24;
                d.bw     = 4'd4;
                d.bh     = 4'd4;
                d.planes = 2'd3;
            end
            default: d.planes = 2'd0;
        endcase
        return d;
    endfunction

    // ceil(2^RECIP_SHIFT / d) for every block dimension in the table
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd4:    m = 22'd524288;
            4'd5:    m = 22'd419431;
            4'd6:    m = 22'd349526;
            4'd8:    m = 22'd262144;
            4'd10:   m = 22'd209716;
            4'd12:   m = 22'd174763;
            default: m = 22'd2097152;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/texture_surface_size.sv
// ----------------------------------------------------------------------------
// texture_surface_size: byte size of a texture layer or image plane
// Four-stage pipeline: format decode and mip shift, block rounding,
// block area, byte scaling into the output register.
// ----------------------------------------------------------------------------
// Takes one size request per clock while o_stall is low; each request passes
// through the four pipeline registers r1 to r4 to the output. A stall on the
// output side backs up through the four pipeline registers, and a request is
// refused only when all four hold an item. The two multiplier stages (block
// rounding by scaled reciprocal, then width times height) and the final
// scaling by bytes per block lie between these registers. Unknown formats and
// out-of-range planes return a zero count with the error flag set.
module texture_surface_size (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [15:0] i_surface_width,
    input  logic [15:0] i_surface_height,
    input  logic [6:0]  i_format_index,
    input  logic [4:0]  i_mip_level,
    input  logic [1:0]  i_plane_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [35:0] o_byte_count,
    output logic        o_error_flag,
    output logic        o_depth_or_stencil,
    output logic [1:0]  o_plane_count
);

    localparam int RW = tss_pkg::RECIP_W;
    localparam int RS = tss_pkg::RECIP_SHIFT;

    // stage enables
    logic en1, en2, en3, en4;

    // stage 1: decode
    logic                 r1_vld;
    logic [16:0]          r1_xw, r1_xh;
    logic [RW-1:0]        r1_mw, r1_mh;
    logic [4:0]           r1_bytes;
    tss_pkg::t_side       r1_side;

    // stage 2: block counts
    logic                 r2_vld;
    logic [15:0]          r2_qw, r2_qh;
    logic [4:0]           r2_bytes;
    tss_pkg::t_side       r2_side;

    // stage 3: block area
    logic                 r3_vld;
    logic [31:0]          r3_area;
    logic [4:0]           r3_bytes;
    tss_pkg::t_side       r3_side;

    // stage 4: output
    logic                 r4_vld;
    logic [35:0]          r4_count;
    tss_pkg::t_side       r4_side;

    logic [16:0]          n_xw, n_xh;
    logic [RW-1:0]        n_mw, n_mh;
    logic [4:0]           n_bytes;
    tss_pkg::t_side       n_side;
    tss_pkg::t_fmt_desc   desc;
    logic [15:0]          lw, lh;
    logic                 unknown, plane_bad, yuv_plane;

    logic [38:0]          pw, ph;
    logic [36:0]          scaled;

    assign en4     = !r4_vld || !i_stall;
    assign en3     = !r3_vld || en4;
    assign en2     = !r2_vld || en3;
    assign en1     = !r1_vld || en2;
    assign o_stall = !en1;

    always_comb begin
        desc      = tss_pkg::fmt_lookup(i_format_index);
        unknown   = (i_format_index >= 7'(tss_pkg::FMT_COUNT));
        plane_bad = i_mode && (i_plane_number >= desc.planes);
        yuv_plane = i_mode
                 && ((i_format_index == 7'(tss_pkg::FMT_NV12))
                  || (i_format_index == 7'(tss_pkg::FMT_YUV420)));

        // plane mode uses the level-0 size
        lw = i_mode ? i_surface_width  : (i_surface_width  >> i_mip_level);
        lh = i_mode ? i_surface_height : (i_surface_height >> i_mip_level);
        if (lw == 16'd0) lw = 16'd1;
        if (lh == 16'd0) lh = 16'd1;

        n_side.err    = unknown || plane_bad;
        n_side.ds     = desc.ds;
        n_side.planes = desc.planes;
        n_side.shift  = 2'd0;
        n_bytes       = (unknown || plane_bad) ? 5'd0 : desc.bytes;

        if (yuv_plane) begin
            // raw area, one byte per texel, divided down by the plane
            n_xw    = {1'b0, i_surface_width};
            n_xh    = {1'b0, i_surface_height};
            n_mw    = tss_pkg::recip(4'd1);
            n_mh    = tss_pkg::recip(4'd1);
            n_bytes = plane_bad ? 5'd0 : 5'd1;
            if (i_format_index == 7'(tss_pkg::FMT_NV12))
                n_side.shift = i_plane_number;
            else
                n_side.shift = (i_plane_number != 2'd0) ? 2'd2 : 2'd0;
        end else begin
            n_xw = {1'b0, lw} + {13'd0, desc.bw} - 17'd1;
            n_xh = {1'b0, lh} + {13'd0, desc.bh} - 17'd1;
            n_mw = tss_pkg::recip(desc.bw);
            n_mh = tss_pkg::recip(desc.bh);
        end
    end

    assign pw     = r1_xw * r1_mw;
    assign ph     = r1_xh * r1_mh;
    assign scaled = (r3_area * r3_bytes) >> r3_side.shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (en1) r1_vld <= i_valid;
            if (en2) r2_vld <= r1_vld;
            if (en3) r3_vld <= r2_vld;
            if (en4) r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_xw    <= n_xw;
            r1_xh    <= n_xh;
            r1_mw    <= n_mw;
            r1_mh    <= n_mh;
            r1_bytes <= n_bytes;
            r1_side  <= n_side;
        end
        if (en2) begin
            r2_qw    <= pw[RS+15:RS];
            r2_qh    <= ph[RS+15:RS];
            r2_bytes <= r1_bytes;
            r2_side  <= r1_side;
        end
        if (en3) begin
            r3_area  <= r2_qw * r2_qh;
            r3_bytes <= r2_bytes;
            r3_side  <= r2_side;
        end
        if (en4) begin
            r4_count <= scaled[35:0];
            r4_side  <= r3_side;
        end
    end

    assign o_valid            = r4_vld;
    assign o_byte_count       = r4_count;
    assign o_error_flag       = r4_side.err;
    assign o_depth_or_stencil = r4_side.ds;
    assign o_plane_count      = r4_side.planes;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_flag |-> o_byte_count == 36'd0)
        else $error("error result with nonzero byte count");

    a_no_planes_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_plane_count == 2'd0) |-> o_error_flag)
        else $error("unknown format without error flag");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r1_vld && r2_vld && r3_vld && r4_vld && i_stall)
        else $error("request refused with a free pipeline slot");

    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_plane_count == 2'd0) |-> !o_depth_or_stencil)
        else $error("unknown format reports depth or stencil");
`endif

endmodule
